FILE: hw/rtl/y86bsd_pkg.sv
package y86bsd_pkg;

  // queue between the byte front end and the assembling back end
  localparam int unsigned QUEUE_DEPTH = 4;

  // dense mnemonic codes
  localparam logic [4:0] MN_HALT   = 5'd0;
  localparam logic [4:0] MN_NOP    = 5'd1;
  localparam logic [4:0] MN_RRMOVL = 5'd2;
  localparam logic [4:0] MN_IRMOVL = 5'd9;
  localparam logic [4:0] MN_RMMOVL = 5'd10;
  localparam logic [4:0] MN_MRMOVL = 5'd11;
  localparam logic [4:0] MN_ADDL   = 5'd12;
  localparam logic [4:0] MN_JMP    = 5'd16;
  localparam logic [4:0] MN_CALL   = 5'd23;
  localparam logic [4:0] MN_RET    = 5'd24;
  localparam logic [4:0] MN_PUSHL  = 5'd25;
  localparam logic [4:0] MN_POPL   = 5'd26;

  // opcode high nibbles
  localparam logic [3:0] OP_HALT   = 4'h0;
  localparam logic [3:0] OP_NOP    = 4'h1;
  localparam logic [3:0] OP_RRMOVL = 4'h2;
  localparam logic [3:0] OP_IRMOVL = 4'h3;
  localparam logic [3:0] OP_RMMOVL = 4'h4;
  localparam logic [3:0] OP_MRMOVL = 4'h5;
  localparam logic [3:0] OP_ALU    = 4'h6;
  localparam logic [3:0] OP_JXX    = 4'h7;
  localparam logic [3:0] OP_CALL   = 4'h8;
  localparam logic [3:0] OP_RET    = 4'h9;
  localparam logic [3:0] OP_PUSHL  = 4'hA;
  localparam logic [3:0] OP_POPL   = 4'hB;

  // highest function code of the families that have several
  localparam logic [3:0] FN_CMOV_MAX = 4'd6;
  localparam logic [3:0] FN_ALU_MAX  = 4'd3;
  localparam logic [3:0] FN_JXX_MAX  = 4'd6;
  localparam logic [3:0] FN_PLAIN    = 4'd0;

  // instruction length classes
  typedef enum logic [1:0] {
    LEN_1,
    LEN_2,
    LEN_5,
    LEN_6
  } len_t;

  // what one queued beat carries to the back end
  typedef enum logic [1:0] {
    BK_OPCODE,
    BK_REG,
    BK_VALUE
  } beat_kind_t;

  typedef struct packed {
    beat_kind_t  kind;
    logic [4:0]  mnemonic;
    logic [7:0]  data;
    logic [1:0]  lane;
    logic        done;
  } beat_t;

  typedef struct packed {
    logic       valid;
    logic [4:0] mnemonic;
    len_t       len;
  } opdec_t;

  function automatic opdec_t decode_opcode(input logic [7:0] op);
    opdec_t     d;
    logic [3:0] hi;
    logic [3:0] lo;
    hi = op[7:4];
    lo = op[3:0];
    d.valid    = 1'b0;
    d.mnemonic = MN_HALT;
    d.len      = LEN_1;
    unique case (hi)
      OP_HALT: begin
        d.valid = (lo == FN_PLAIN); d.mnemonic = MN_HALT; d.len = LEN_1;
      end
      OP_NOP: begin
        d.valid = (lo == FN_PLAIN); d.mnemonic = MN_NOP; d.len = LEN_1;
      end
      OP_RRMOVL: begin
        d.valid = (lo <= FN_CMOV_MAX);
        d.mnemonic = MN_RRMOVL + {1'b0, lo}; d.len = LEN_2;
      end
      OP_IRMOVL: begin
        d.valid = (lo == FN_PLAIN); d.mnemonic = MN_IRMOVL; d.len = LEN_6;
      end
      OP_RMMOVL: begin
        d.valid = (lo == FN_PLAIN); d.mnemonic = MN_RMMOVL; d.len = LEN_6;
      end
      OP_MRMOVL: begin
        d.valid = (lo == FN_PLAIN); d.mnemonic = MN_MRMOVL; d.len = LEN_6;
      end
      OP_ALU: begin
        d.valid = (lo <= FN_ALU_MAX);
        d.mnemonic = MN_ADDL + {1'b0, lo}; d.len = LEN_2;
      end
      OP_JXX: begin
        d.valid = (lo <= FN_JXX_MAX);
        d.mnemonic = MN_JMP + {1'b0, lo}; d.len = LEN_5;
      end
      OP_CALL: begin
        d.valid = (lo == FN_PLAIN); d.mnemonic = MN_CALL; d.len = LEN_5;
      end
      OP_RET: begin
        d.valid = (lo == FN_PLAIN); d.mnemonic = MN_RET; d.len = LEN_1;
      end
      OP_PUSHL: begin
        d.valid = (lo == FN_PLAIN); d.mnemonic = MN_PUSHL; d.len = LEN_2;
      end
      OP_POPL: begin
        d.valid = (lo == FN_PLAIN); d.mnemonic = MN_POPL; d.len = LEN_2;
      end
      default: begin
        d.valid = 1'b0;
      end
    endcase
    return d;
  endfunction

endpackage

FILE: hw/rtl/y86bsd_front.sv
module y86bsd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         code_byte,
  input  logic               last_byte,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               q_full,
  output logic               push,
  output y86bsd_pkg::beat_t  push_beat
);

  logic [2:0]       phase;
  logic [2:0]       phase_next;
  y86bsd_pkg::len_t len_class;
  y86bsd_pkg::len_t len_class_next;
  y86bsd_pkg::opdec_t dec;
  logic             accept;
  logic             need_push;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign dec      = y86bsd_pkg::decode_opcode(code_byte);
  assign push     = accept && need_push;

  // classify the byte by phase and length class
  always_comb begin
    need_push          = 1'b0;
    push_beat.kind     = y86bsd_pkg::BK_OPCODE;
    push_beat.mnemonic = dec.mnemonic;
    push_beat.data     = code_byte;
    push_beat.lane     = 2'd0;
    push_beat.done     = 1'b0;
    phase_next         = phase;
    len_class_next     = len_class;
    if (phase == 3'd0) begin
      if (dec.valid) begin
        need_push      = 1'b1;
        push_beat.done = (dec.len == y86bsd_pkg::LEN_1);
        len_class_next = dec.len;
        phase_next     = (dec.len == y86bsd_pkg::LEN_1) ? 3'd0 : 3'd1;
      end
    end else begin
      need_push = 1'b1;
      if (len_class == y86bsd_pkg::LEN_5) begin
        push_beat.kind = y86bsd_pkg::BK_VALUE;
        push_beat.lane = 2'(phase - 3'd1);
        push_beat.done = (phase == 3'd4);
      end else if (phase == 3'd1) begin
        push_beat.kind = y86bsd_pkg::BK_REG;
        push_beat.done = (len_class != y86bsd_pkg::LEN_6);
      end else begin
        push_beat.kind = y86bsd_pkg::BK_VALUE;
        push_beat.lane = 2'(phase - 3'd2);
        push_beat.done = (phase == 3'd5);
      end
      phase_next = push_beat.done ? 3'd0 : phase + 3'd1;
    end
    // end of stream drops any partial instruction
    if (last_byte) begin
      phase_next = 3'd0;
    end
  end

  // phase counter and length class
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= 3'd0;
      len_class <= y86bsd_pkg::LEN_1;
    end else if (accept) begin
      phase     <= phase_next;
      len_class <= len_class_next;
    end
  end

endmodule

FILE: hw/rtl/y86bsd_queue.sv
module y86bsd_queue #(
  parameter int unsigned DEPTH = y86bsd_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  y86bsd_pkg::beat_t push_beat,
  output logic              full,
  output logic              not_empty,
  input  logic              pop,
  output y86bsd_pkg::beat_t pop_beat
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  y86bsd_pkg::beat_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == FULL_COUNT);
  assign not_empty = (count != '0);
  assign pop_beat  = slots[rd_ptr];

  // beat storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_beat;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: hw/rtl/y86bsd_back.sv
module y86bsd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_not_empty,
  input  y86bsd_pkg::beat_t pop_beat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [4:0]        mnemonic,
  output logic [3:0]        reg_a,
  output logic [3:0]        reg_b,
  output logic [31:0]       value_word
);

  logic [4:0]  pend_mn;
  logic [7:0]  reg_byte;
  logic [31:0] acc;
  logic [4:0]  pend_mn_next;
  logic [7:0]  reg_byte_next;
  logic [31:0] acc_next;

  assign pop = q_not_empty && (!out_valid || !out_stall);

  // fold one beat into the instruction being assembled
  always_comb begin
    pend_mn_next  = pend_mn;
    reg_byte_next = reg_byte;
    acc_next      = acc;
    unique case (pop_beat.kind)
      y86bsd_pkg::BK_OPCODE: begin
        pend_mn_next  = pop_beat.mnemonic;
        reg_byte_next = 8'd0;
        acc_next      = 32'd0;
      end
      y86bsd_pkg::BK_REG: begin
        reg_byte_next = pop_beat.data;
      end
      y86bsd_pkg::BK_VALUE: begin
        acc_next = acc | ({24'd0, pop_beat.data} << {pop_beat.lane, 3'd0});
      end
      default: begin
        acc_next = acc;
      end
    endcase
  end

  // assembly registers
  always_ff @(posedge clk) begin
    if (pop) begin
      pend_mn  <= pend_mn_next;
      reg_byte <= reg_byte_next;
      acc      <= acc_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= pop_beat.done;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && pop_beat.done) begin
      mnemonic   <= pend_mn_next;
      reg_a      <= reg_byte_next[7:4];
      reg_b      <= reg_byte_next[3:0];
      value_word <= acc_next;
    end
  end

endmodule

FILE: hw/rtl/y86_byte_stream_decoder_top.sv
// Y86 byte-stream decoder: takes one program byte per beat on the input channel and gives
// one beat per complete instruction on the output channel (mnemonic code, register nibbles
// and little-endian 32-bit value, zero where the instruction has none). A byte is taken
// every cycle unless the beat queue is full; each result passes through the queue and the
// output register after the final byte of its instruction. Sustained rate is one byte per
// cycle while the queue has room; a queue of QUEUE_DEPTH beats lets the input keep running
// while the output is stalled, until it fills. Unknown opcodes use up one byte and give no
// result, and a byte marked last_byte ends any partial instruction after it is processed.
module y86_byte_stream_decoder_top #(
  parameter int unsigned QUEUE_DEPTH = y86bsd_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  code_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  mnemonic,
  output logic [3:0]  reg_a,
  output logic [3:0]  reg_b,
  output logic [31:0] value_word
);

  logic              q_full;
  logic              q_not_empty;
  logic              push;
  logic              pop;
  y86bsd_pkg::beat_t push_beat;
  y86bsd_pkg::beat_t pop_beat;

  // byte classification
  y86bsd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .code_byte (code_byte),
    .last_byte (last_byte),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .q_full    (q_full),
    .push      (push),
    .push_beat (push_beat)
  );

  // beat queue
  y86bsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_beat (push_beat),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop       (pop),
    .pop_beat  (pop_beat)
  );

  // instruction assembly and output register
  y86bsd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .pop_beat    (pop_beat),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .mnemonic    (mnemonic),
    .reg_a       (reg_a),
    .reg_b       (reg_b),
    .value_word  (value_word)
  );

endmodule

FILE: sim/tb_y86_byte_stream_decoder_top.sv
`timescale 1ns / 100ps

module tb_y86_byte_stream_decoder_top;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_BYTES = 700;

  typedef struct packed {
    logic [4:0]  mn;
    logic [3:0]  ra;
    logic [3:0]  rb;
    logic [31:0] val;
  } decoded_t;

  // predicts decoded instructions from the byte stream and checks the output beats
  class instr_decode_board;
    decoded_t             expected_instrs[$];
    logic [2:0]           phase;
    logic [4:0]           cur_mn;
    y86bsd_pkg::len_t     cur_len;
    logic [7:0]           reg_byte;
    logic [31:0]          val_acc;
    int                   errors;
    int                   checked;
    bit [31:0]            seen_mask;

    function new();
      clear();
      errors    = 0;
      checked   = 0;
      seen_mask = '0;
    endfunction

    function void clear();
      phase    = '0;
      cur_mn   = y86bsd_pkg::MN_HALT;
      cur_len  = y86bsd_pkg::LEN_1;
      reg_byte = '0;
      val_acc  = '0;
    endfunction

    static function int span(y86bsd_pkg::len_t len);
      case (len)
        y86bsd_pkg::LEN_1: return 1;
        y86bsd_pkg::LEN_2: return 2;
        y86bsd_pkg::LEN_5: return 5;
        default:           return 6;
      endcase
    endfunction

    // opcode byte to mnemonic and length class, 0 for an unknown opcode
    static function bit lookup(input logic [7:0] op, output logic [4:0] mn,
                               output y86bsd_pkg::len_t len);
      logic [3:0] hi;
      logic [3:0] fn;
      bit         ok;
      hi  = op[7:4];
      fn  = op[3:0];
      ok  = (fn == y86bsd_pkg::FN_PLAIN);
      mn  = y86bsd_pkg::MN_HALT;
      len = y86bsd_pkg::LEN_1;
      case (hi)
        y86bsd_pkg::OP_HALT:   mn = y86bsd_pkg::MN_HALT;
        y86bsd_pkg::OP_NOP:    mn = y86bsd_pkg::MN_NOP;
        y86bsd_pkg::OP_RET:    mn = y86bsd_pkg::MN_RET;
        y86bsd_pkg::OP_RRMOVL: begin
          ok  = (fn <= y86bsd_pkg::FN_CMOV_MAX);
          mn  = y86bsd_pkg::MN_RRMOVL + {1'b0, fn};
          len = y86bsd_pkg::LEN_2;
        end
        y86bsd_pkg::OP_ALU: begin
          ok  = (fn <= y86bsd_pkg::FN_ALU_MAX);
          mn  = y86bsd_pkg::MN_ADDL + {1'b0, fn};
          len = y86bsd_pkg::LEN_2;
        end
        y86bsd_pkg::OP_PUSHL: begin
          mn = y86bsd_pkg::MN_PUSHL; len = y86bsd_pkg::LEN_2;
        end
        y86bsd_pkg::OP_POPL: begin
          mn = y86bsd_pkg::MN_POPL; len = y86bsd_pkg::LEN_2;
        end
        y86bsd_pkg::OP_IRMOVL: begin
          mn = y86bsd_pkg::MN_IRMOVL; len = y86bsd_pkg::LEN_6;
        end
        y86bsd_pkg::OP_RMMOVL: begin
          mn = y86bsd_pkg::MN_RMMOVL; len = y86bsd_pkg::LEN_6;
        end
        y86bsd_pkg::OP_MRMOVL: begin
          mn = y86bsd_pkg::MN_MRMOVL; len = y86bsd_pkg::LEN_6;
        end
        y86bsd_pkg::OP_JXX: begin
          ok  = (fn <= y86bsd_pkg::FN_JXX_MAX);
          mn  = y86bsd_pkg::MN_JMP + {1'b0, fn};
          len = y86bsd_pkg::LEN_5;
        end
        y86bsd_pkg::OP_CALL: begin
          mn = y86bsd_pkg::MN_CALL; len = y86bsd_pkg::LEN_5;
        end
        default: ok = 1'b0;
      endcase
      return ok;
    endfunction

    // note one accepted input beat; returns 0 when the byte was ignored
    function bit take_byte(logic [7:0] b, logic last);
      logic [4:0]       mn;
      y86bsd_pkg::len_t len;
      bit               done;
      bit               used;
      int               idx;
      decoded_t         d;
      done = 1'b0;
      used = 1'b1;
      if (phase == 3'd0) begin
        if (lookup(b, mn, len)) begin
          cur_mn   = mn;
          cur_len  = len;
          reg_byte = '0;
          val_acc  = '0;
          if (len == y86bsd_pkg::LEN_1) done = 1'b1;
          else phase = 3'd1;
        end else begin
          used = 1'b0;
        end
      end else begin
        idx = int'(phase);
        // jumps and call carry the value right after the opcode
        if (cur_len == y86bsd_pkg::LEN_5) val_acc |= {24'd0, b} << (8 * (idx - 1));
        else if (idx == 1) reg_byte = b;
        else val_acc |= {24'd0, b} << (8 * (idx - 2));
        if (idx + 1 >= span(cur_len)) done = 1'b1;
        else phase = 3'(idx + 1);
      end
      if (done) begin
        d.mn  = cur_mn;
        d.ra  = (cur_len == y86bsd_pkg::LEN_2 || cur_len == y86bsd_pkg::LEN_6) ?
                reg_byte[7:4] : 4'd0;
        d.rb  = (cur_len == y86bsd_pkg::LEN_2 || cur_len == y86bsd_pkg::LEN_6) ?
                reg_byte[3:0] : 4'd0;
        d.val = val_acc;
        expected_instrs.push_back(d);
        clear();
      end
      // last-byte mark drops whatever is partly collected
      if (last) clear();
      return used;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%0t: %s", $time, msg);
    endfunction

    // compare one output beat against the oldest predicted instruction
    function void check_decoded(logic [4:0] mn, logic [3:0] ra, logic [3:0] rb,
                                logic [31:0] val);
      decoded_t want;
      if (expected_instrs.size() == 0) begin
        flag($sformatf("unexpected beat: mnemonic %0d reg_a %h reg_b %h value %h",
                       mn, ra, rb, val));
      end else begin
        want = expected_instrs.pop_front();
        checked++;
        seen_mask[mn] = 1'b1;
        if (mn !== want.mn || ra !== want.ra || rb !== want.rb || val !== want.val)
          flag($sformatf("mismatch: expected %0d/%h/%h/%h, got %0d/%h/%h/%h",
                         want.mn, want.ra, want.rb, want.val, mn, ra, rb, val));
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  code_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  mnemonic;
  logic [3:0]  reg_a;
  logic [3:0]  reg_b;
  logic [31:0] value_word;

  instr_decode_board board;
  bit steady = 1'b0;
  int used_bytes = 0;
  int ignored_bytes = 0;
  int cut_instrs = 0;
  int stall_run = 0;
  int idle_cycles = 0;

  y86_byte_stream_decoder_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .code_byte  (code_byte),
    .last_byte  (last_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .mnemonic   (mnemonic),
    .reg_a      (reg_a),
    .reg_b      (reg_b),
    .value_word (value_word)
  );

  always #5 clk = ~clk;

  // mostly short gaps, a few long ones, none in steady stretches
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 9);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic [7:0] rand_opcode();
    logic [3:0] hi;
    logic [3:0] fn;
    hi = 4'($urandom_range(y86bsd_pkg::OP_HALT, y86bsd_pkg::OP_POPL));
    case (hi)
      y86bsd_pkg::OP_RRMOVL:
        fn = 4'($urandom_range(y86bsd_pkg::FN_PLAIN, y86bsd_pkg::FN_CMOV_MAX));
      y86bsd_pkg::OP_ALU:
        fn = 4'($urandom_range(y86bsd_pkg::FN_PLAIN, y86bsd_pkg::FN_ALU_MAX));
      y86bsd_pkg::OP_JXX:
        fn = 4'($urandom_range(y86bsd_pkg::FN_PLAIN, y86bsd_pkg::FN_JXX_MAX));
      default:
        fn = y86bsd_pkg::FN_PLAIN;
    endcase
    return {hi, fn};
  endfunction

  function automatic logic [7:0] rand_reg();
    logic [7:0] r;
    r = 8'($urandom);
    if ($urandom_range(0, 3) == 0) r[7:4] = 4'hF;
    if ($urandom_range(0, 3) == 0) r[3:0] = 4'hF;
    return r;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // one input beat, held until accepted
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    code_byte <= b;
    last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (board.take_byte(b, last)) used_bytes++;
    else ignored_bytes++;
  endtask

  // whole instruction; cut is the byte that carries the last mark, -1 for none
  task automatic send_instr(input logic [7:0] op, input logic [7:0] rb,
                            input logic [31:0] val, input int cut);
    logic [4:0]       mn;
    y86bsd_pkg::len_t len;
    int               n;
    logic [7:0]       bytes [6];
    if (!instr_decode_board::lookup(op, mn, len)) begin
      send_byte(op, cut == 0);
      return;
    end
    n = instr_decode_board::span(len);
    bytes[0] = op;
    if (len == y86bsd_pkg::LEN_5) begin
      for (int i = 0; i < 4; i++) bytes[1 + i] = val[8 * i +: 8];
    end else begin
      bytes[1] = rb;
      for (int i = 0; i < 4; i++) bytes[2 + i] = val[8 * i +: 8];
    end
    for (int i = 0; i < n; i++) begin
      send_byte(bytes[i], i == cut);
      if (i == cut) begin
        if (i < n - 1) cut_instrs++;
        break;
      end
    end
  endtask

  // output side: check accepted beats, then pick the stall for the next cycle
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_decoded(mnemonic, reg_a, reg_b, value_word);
    if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run--;
    end else if ($urandom_range(0, 2) == 0) begin
      stall_run = pick_gap();
      out_stall <= (stall_run > 0);
      if (stall_run > 0) stall_run--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [7:0]       op;
    logic [4:0]       mn;
    y86bsd_pkg::len_t len;
    int               r;
    int               cut;
    board = new();
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    code_byte <= '0;
    last_byte <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: every length class, field extremes, raw nibbles, unknowns, last mark
    send_instr({y86bsd_pkg::OP_HALT, y86bsd_pkg::FN_PLAIN}, 8'h00, '0, -1);
    send_instr({y86bsd_pkg::OP_NOP, y86bsd_pkg::FN_PLAIN}, 8'h00, '0, -1);
    send_instr({y86bsd_pkg::OP_RET, y86bsd_pkg::FN_PLAIN}, 8'h00, '0, -1);
    send_instr({y86bsd_pkg::OP_RRMOVL, y86bsd_pkg::FN_PLAIN}, 8'h00, '0, -1);
    send_instr({y86bsd_pkg::OP_RRMOVL, y86bsd_pkg::FN_CMOV_MAX}, 8'hFF, '0, -1);
    send_instr({y86bsd_pkg::OP_IRMOVL, y86bsd_pkg::FN_PLAIN}, 8'hF3, 32'hFFFF_FFFF, -1);
    send_instr({y86bsd_pkg::OP_RMMOVL, y86bsd_pkg::FN_PLAIN}, 8'h45, 32'h0000_0000, -1);
    send_instr({y86bsd_pkg::OP_MRMOVL, y86bsd_pkg::FN_PLAIN}, 8'h67, 32'h8000_0001, -1);
    send_instr({y86bsd_pkg::OP_ALU, y86bsd_pkg::FN_ALU_MAX}, 8'h12, '0, -1);
    send_instr({y86bsd_pkg::OP_JXX, y86bsd_pkg::FN_JXX_MAX}, 8'h00, 32'h0000_0100, -1);
    send_instr({y86bsd_pkg::OP_CALL, y86bsd_pkg::FN_PLAIN}, 8'h00, 32'hA5C3_5A3C, -1);
    send_instr({y86bsd_pkg::OP_PUSHL, y86bsd_pkg::FN_PLAIN}, 8'h4F, '0, -1);
    send_instr({y86bsd_pkg::OP_POPL, y86bsd_pkg::FN_PLAIN}, 8'hF0, '0, -1);
    send_instr(8'hFF, 8'h00, '0, -1);
    send_instr({y86bsd_pkg::OP_RRMOVL, y86bsd_pkg::FN_CMOV_MAX + 4'd1}, 8'h00, '0, -1);
    send_instr({y86bsd_pkg::OP_HALT, y86bsd_pkg::FN_PLAIN + 4'd1}, 8'h00, '0, -1);
    // mark on the completing byte, in the middle, on an unknown and on opcodes
    send_instr({y86bsd_pkg::OP_ALU, y86bsd_pkg::FN_PLAIN}, 8'h9A, '0, 1);
    send_instr({y86bsd_pkg::OP_IRMOVL, y86bsd_pkg::FN_PLAIN}, 8'h2F, 32'h1234_5678, 3);
    send_instr({y86bsd_pkg::OP_NOP, y86bsd_pkg::FN_PLAIN}, 8'h00, '0, -1);
    send_instr(8'hC0, 8'h00, '0, 0);
    send_instr({y86bsd_pkg::OP_HALT, y86bsd_pkg::FN_PLAIN}, 8'h00, '0, 0);
    send_instr({y86bsd_pkg::OP_CALL, y86bsd_pkg::FN_PLAIN}, 8'h00, 32'h0000_0040, 0);
    send_instr({y86bsd_pkg::OP_RET, y86bsd_pkg::FN_PLAIN}, 8'h00, '0, -1);

    // random: mostly well-formed instructions, some cut short, some noise
    while (used_bytes < RANDOM_BYTES) begin
      if ($urandom_range(0, 39) == 0) steady = !steady;
      r = $urandom_range(0, 99);
      if (r < 84) begin
        cut = ($urandom_range(0, 14) == 0) ? $urandom_range(0, 5) : -1;
        send_instr(rand_opcode(), rand_reg(), rand_value(), cut);
      end else if (r < 94) begin
        send_byte(8'($urandom), $urandom_range(0, 19) == 0);
      end else begin
        do op = 8'($urandom); while (instr_decode_board::lookup(op, mn, len));
        send_instr(op, 8'h00, '0, $urandom_range(0, 3) == 0 ? 0 : -1);
      end
    end
    in_valid <= 1'b0;
    steady = 1'b0;

    // let the queue and output side drain
    while (board.expected_instrs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d program bytes (%0d ignored as unknown opcodes), %0d instructions cut",
             used_bytes + ignored_bytes, ignored_bytes, cut_instrs);
    $display("checked %0d decoded beats covering %0d of 27 mnemonics, %0d mismatches",
             board.checked, $countones(board.seen_mask), board.errors);
    if (board.errors == 0 && board.expected_instrs.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/y86bsd_pkg.sv
hw/rtl/y86bsd_front.sv
hw/rtl/y86bsd_queue.sv
hw/rtl/y86bsd_back.sv
hw/rtl/y86_byte_stream_decoder_top.sv
sim/tb_y86_byte_stream_decoder_top.sv
